// File: rtl/core/cfpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfpm_pkg;

	// Window depth: longest pattern the matcher can compare.
	localparam int PATTERN_MAX = 16;

	// Pattern bytes that the two 64-bit registers can hold.
	localparam int PAT_BYTES = 16;
	localparam int PAT_IDX_W = $clog2(PAT_BYTES);

	// Count must hold PATTERN_MAX + 1 and the full 5-bit length register.
	localparam int CNT_RAW_W = $clog2(PATTERN_MAX + 2);
	localparam int CNT_W = (CNT_RAW_W > 5) ? CNT_RAW_W : 5;

	localparam int LEN_REG_W = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CASE_DELTA = CH_LOWER_A - CH_UPPER_A;

	typedef enum logic [1:0] {
		MODE_EXACT,
		MODE_PREFIX,
		MODE_SUFFIX,
		MODE_CONTAINS
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE,
		REG_LEN,
		REG_PAT_LO,
		REG_PAT_HI
	} reg_idx_t;

	// Per-beat control fanned out to every window cell.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b);
		if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
			return b - CASE_DELTA;
		end
		return b;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/cfpm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One window slot: holds a folded byte, passes it on each shift and
// checks it (current and incoming) against its pattern byte.
module cfpm_cell
	import cfpm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctl_t  ctl,
	input  wire logic [7:0] byte_in,
	input  wire logic [7:0] exp_byte,
	input  wire logic       used,
	output logic [7:0]      byte_out,
	output logic            eq_cur,
	output logic            eq_nxt
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= CH_NUL;
		end else if (ctl.clear) begin
			byte_q <= CH_NUL;
		end else if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

	// A zero pattern byte never matches a string byte.
	assign eq_cur = !used || (byte_q == exp_byte && exp_byte != CH_NUL);
	assign eq_nxt = !used || (byte_in == exp_byte && exp_byte != CH_NUL);
	assign byte_out = byte_q;

endmodule

`default_nettype wire

// File: rtl/core/case_fold_pattern_matcher_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Case-insensitive serial string matcher.
// Input channel: one string byte per beat on char_byte (in_valid/in_stall);
// a zero byte terminates the string. Only the terminator beat produces a
// result: one beat on the output channel (out_valid/out_stall) carrying
// match. Letters a..z are folded to upper case on both string and pattern.
// Latency: the result is valid the cycle after the terminator is accepted.
// Throughput: one byte per cycle while in_stall is low, strings back to back; the
// window is a shift chain of PATTERN_MAX cells, each comparing its byte
// with its pattern byte in parallel, so a byte never waits on the compare.
// Stall: while a result is held and out_stall is high, in_stall is high;
// otherwise every input beat is taken at once, even with a result pending.
// Reset (arst_n low): registers clear to mode exact, length zero, pattern
// zero; window, count and hit flags clear, no result pending.
// Config: APB, 64-bit data, register i at byte address 8*i; write only
// between strings. Length zero matches every string.
module case_fold_pattern_matcher_top
	import cfpm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// byte input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            char_byte,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       match,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);

	// ---------------- configuration registers ----------------
	mode_t                 mode_q;
	logic [LEN_REG_W-1:0]  len_q;
	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	reg_idx_t              reg_idx;
	logic                  cfg_wr;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_EXACT;
			len_q    <= '0;
			pat_lo_q <= '0;
			pat_hi_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MODE:   mode_q <= mode_t'(pwdata[1:0]);
				REG_LEN:    len_q <= pwdata[LEN_REG_W-1:0];
				REG_PAT_LO: pat_lo_q <= pwdata;
				REG_PAT_HI: pat_hi_q <= pwdata;
				default:    mode_q <= mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MODE:   prdata = {{(CFG_DATA_W-2){1'b0}}, mode_q};
			REG_LEN:    prdata = {{(CFG_DATA_W-LEN_REG_W){1'b0}}, len_q};
			REG_PAT_LO: prdata = pat_lo_q;
			REG_PAT_HI: prdata = pat_hi_q;
			default:    prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	logic out_valid_q;
	logic match_q;
	logic in_fire;
	logic is_term;

	// Input only waits when the held result cannot leave this cycle.
	assign in_stall = out_valid_q && out_stall;
	assign in_fire = in_valid && !in_stall;
	assign is_term = (char_byte == CH_NUL);

	// ---------------- per-cell expected bytes ----------------
	logic [CNT_W-1:0] len_eff;
	logic [CNT_W-1:0] len_ext;
	logic [7:0]       pat_byte [PAT_BYTES];
	logic [7:0]       exp_byte [PATTERN_MAX];
	logic             used     [PATTERN_MAX];

	assign len_ext = CNT_W'(len_q);
	assign len_eff = (len_ext > CNT_W'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX) : len_ext;

	always_comb begin
		for (int b = 0; b < PAT_BYTES; b++) begin
			if (b < 8) begin
				pat_byte[b] = pat_lo_q[8*(b%8) +: 8];
			end else begin
				pat_byte[b] = pat_hi_q[8*(b%8) +: 8];
			end
		end
	end

	// Cell k (k-th newest byte) lines up with pattern byte len-1-k.
	always_comb begin
		logic [CNT_W-1:0] j;
		for (int k = 0; k < PATTERN_MAX; k++) begin
			j = len_eff - CNT_W'(1) - CNT_W'(k);
			used[k] = CNT_W'(k) < len_eff;
			if (used[k] && j < CNT_W'(PAT_BYTES)) begin
				exp_byte[k] = fold_byte(pat_byte[j[PAT_IDX_W-1:0]]);
			end else begin
				exp_byte[k] = CH_NUL;
			end
		end
	end

	// ---------------- window chain ----------------
	cell_ctl_t             cell_ctl;
	logic [7:0]            win      [PATTERN_MAX];
	logic [7:0]            win_in   [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] eq_cur;
	logic [PATTERN_MAX-1:0] eq_nxt;

	assign cell_ctl.shift = in_fire && !is_term;
	assign cell_ctl.clear = in_fire && is_term;

	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign win_in[k] = fold_byte(char_byte);
		end else begin : g_link
			assign win_in[k] = win[k-1];
		end
		cfpm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.byte_in  (win_in[k]),
			.exp_byte (exp_byte[k]),
			.used     (used[k]),
			.byte_out (win[k]),
			.eq_cur   (eq_cur[k]),
			.eq_nxt   (eq_nxt[k])
		);
	end

	// ---------------- count and hit flags ----------------
	logic [CNT_W-1:0] seen_q;
	logic [CNT_W-1:0] seen_nxt;
	logic             prefix_q;
	logic             contains_q;
	logic             hit_nxt;
	logic             result;

	assign seen_nxt = (seen_q < CNT_W'(PATTERN_MAX + 1)) ? seen_q + CNT_W'(1) : seen_q;
	assign hit_nxt = (len_eff != '0) && (seen_nxt >= len_eff) && (&eq_nxt);

	always_comb begin
		if (len_eff == '0) begin
			result = 1'b1;
		end else begin
			unique case (mode_q)
				MODE_EXACT:    result = prefix_q && (seen_q == len_eff);
				MODE_PREFIX:   result = prefix_q;
				MODE_SUFFIX:   result = (seen_q >= len_eff) && (&eq_cur);
				MODE_CONTAINS: result = contains_q;
				default:       result = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			prefix_q   <= 1'b0;
			contains_q <= 1'b0;
		end else if (in_fire) begin
			if (is_term) begin
				seen_q     <= '0;
				prefix_q   <= 1'b0;
				contains_q <= 1'b0;
			end else begin
				seen_q <= seen_nxt;
				if (hit_nxt) begin
					contains_q <= 1'b1;
					if (seen_nxt == len_eff) begin
						prefix_q <= 1'b1;
					end
				end
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && is_term) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_term) begin
			match_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign match = match_q;

`ifndef SYNTHESIS
	a_term_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_term |=> out_valid_q)
		else $error("terminator beat produced no result");

	a_prefix_implies_contains: assert property (@(posedge clk) disable iff (!arst_n)
		prefix_q |-> contains_q)
		else $error("prefix hit without contains hit");

	a_term_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_term |=> seen_q == '0 && !prefix_q && !contains_q)
		else $error("string state not cleared after terminator");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= CNT_W'(PATTERN_MAX + 1))
		else $error("byte count beyond saturation");
`endif

endmodule

`default_nettype wire

// File: tb/case_fold_pattern_matcher_top_tb.sv
`timescale 1ns / 1ps

module case_fold_pattern_matcher_top_tb;
	import cfpm_pkg::*;

	// Run shape
	localparam int RANDOM_ITEMS   = 1300;
	localparam int HOLDOFF_CYCLES = 200;   // long receiver hold-off, fills the block
	localparam int SETTLE_CYCLES  = 4;     // result lands in the cycle after the terminator
	localparam int CYCLE_LIMIT    = 200000;

	// Where the expected match of a directed string comes from
	typedef enum logic [1:0] {
		WANT_MODEL,
		WANT_MISS,
		WANT_HIT
	} want_t;

	// One directed string: optional register setup, up to four bytes, then the terminator
	typedef struct packed {
		logic        set_cfg;
		mode_t       mode;
		logic [4:0]  plen;
		logic [63:0] pat_lo;
		logic [63:0] pat_hi;
		logic [2:0]  n;
		logic [31:0] text;     // byte 0 in bits 7..0
		want_t       want;
	} probe_t;

	localparam probe_t PROBES [8] = '{
		// reset values: empty pattern, empty string matches
		'{1'b0, MODE_EXACT, 5'd0, 64'h0, 64'h0, 3'd0, 32'h0, WANT_HIT},
		// empty pattern still matches with the top byte value
		'{1'b0, MODE_EXACT, 5'd0, 64'h0, 64'h0, 3'd1, 32'hFF, WANT_HIT},
		// exact, lower-case pattern against upper-case string
		'{1'b1, MODE_EXACT, 5'd3, 64'h636261, 64'h0, 3'd3, 32'h434241, WANT_HIT},
		// prefix with mixed case and trailing 'z'
		'{1'b1, MODE_PREFIX, 5'd2, 64'h6261, 64'h0, 3'd3, 32'h7A4261, WANT_MODEL},
		// suffix "yz" at the end of "xYZ"
		'{1'b1, MODE_SUFFIX, 5'd2, 64'h7A79, 64'h0, 3'd3, 32'h5A5978, WANT_HIT},
		// bytes just outside a..z do not fold: "`{" never equals "@["
		'{1'b1, MODE_CONTAINS, 5'd2, 64'h7B60, 64'h0, 3'd2, 32'h5B40, WANT_MISS},
		// zero byte inside the pattern never matches
		'{1'b1, MODE_EXACT, 5'd2, 64'h0041, 64'h0, 3'd2, 32'h4241, WANT_MISS},
		// length 31 is taken as 16, so "zz" cannot contain it
		'{1'b1, MODE_CONTAINS, 5'd31, 64'h5A5A5A5A5A5A5A5A, 64'h5A5A5A5A5A5A5A5A,
			3'd2, 32'h7A7A, WANT_MISS}
	};

	// DUT ports, all driven inputs known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        match;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic        pready;

	// Register copy held by the predictor (reset values)
	mode_t       cfg_mode = MODE_EXACT;
	logic [4:0]  cfg_len = '0;
	logic [63:0] cfg_pat_lo = '0;
	logic [63:0] cfg_pat_hi = '0;

	// String-side predictor state: folded window (newest at 0), saturating count, sticky flags
	logic [7:0]  seen_tail [PATTERN_MAX] = '{default: '0};
	int unsigned seen_count = 0;
	bit          head_hit = 1'b0;
	bit          any_hit = 1'b0;

	bit          match_due [$];      // expected match bits, oldest first
	want_t       next_want = WANT_MODEL;
	int          mismatches = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	int          tx_idle_pct = 32;
	int          rx_idle_pct = 63;
	int          holdoff_requests = 0;

	case_fold_pattern_matcher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_byte (char_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.match     (match),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic logic [7:0] upcase(input logic [7:0] b);
		return (b >= CH_LOWER_A && b <= CH_LOWER_Z) ? b - CASE_DELTA : b;
	endfunction

	// Pattern byte i as the registers hold it; zero past the two registers
	function automatic logic [7:0] pattern_char(input int i);
		if (i < 8) begin
			return cfg_pat_lo[8*i +: 8];
		end
		if (i < 16) begin
			return cfg_pat_hi[8*(i-8) +: 8];
		end
		return CH_NUL;
	endfunction

	// Newest n window bytes spell pattern bytes 0..n-1
	function automatic bit tail_is_pattern(input int n);
		logic [7:0] p;
		for (int i = 0; i < n; i++) begin
			p = pattern_char(i);
			if (p == CH_NUL || seen_tail[n-1-i] != upcase(p)) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// One accepted byte; on the terminator returns the match bit and clears the string
	task automatic matcher_step(input logic [7:0] b, output bit done, output bit hit);
		int n;
		n = (cfg_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_len);
		done = 1'b0;
		hit = 1'b0;
		if (b != CH_NUL) begin
			for (int i = PATTERN_MAX - 1; i > 0; i--) begin
				seen_tail[i] = seen_tail[i-1];
			end
			seen_tail[0] = upcase(b);
			if (seen_count < PATTERN_MAX + 1) begin
				seen_count++;
			end
			if (n > 0 && seen_count >= n && tail_is_pattern(n)) begin
				any_hit = 1'b1;
				if (seen_count == n) begin
					head_hit = 1'b1;
				end
			end
		end else begin
			done = 1'b1;
			if (n == 0) begin
				hit = 1'b1;
			end else begin
				case (cfg_mode)
					MODE_EXACT:  hit = head_hit && seen_count == n;
					MODE_PREFIX: hit = head_hit;
					MODE_SUFFIX: hit = seen_count >= n && tail_is_pattern(n);
					default:     hit = any_hit;
				endcase
			end
			seen_tail = '{default: '0};
			seen_count = 0;
			head_hit = 1'b0;
			any_hit = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------
	// Monitor: result beats checked first, then the accepted byte is
	// fed to the predictor, so a same-edge result never sees its own
	// expectation.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : watch
		bit done;
		bit hit;
		bit due;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (match_due.size() == 0) begin
					$error("match: expected none, actual %0b", match);
					mismatches++;
				end else begin
					due = match_due.pop_front();
					if (match !== due) begin
						$error("match: expected %0b, actual %0b", due, match);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				matcher_step(char_byte, done, hit);
				if (done) begin
					match_due.push_back(next_want == WANT_MODEL ? hit : next_want == WANT_HIT);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random stall, or a long hold-off when the stimulus
	// asks for one. The hold-off is counted here so the sender keeps
	// offering beats and the block backs up into in_stall.
	// ---------------------------------------------------------------
	initial begin : result_sink
		int hold_left;
		int holds_taken;
		hold_left = 0;
		holds_taken = 0;
		forever begin
			@(posedge clk);
			if (holds_taken != holdoff_requests) begin
				holds_taken = holdoff_requests;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// APB write: setup cycle, then access; the register takes it at the
	// edge with psel, penable, pwrite and pready all high. The bus is
	// left driven; the caller returns it to idle after its last write.
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'({idx, 3'b000});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MODE:   cfg_mode = mode_t'(value[1:0]);
			REG_LEN:    cfg_len = value[4:0];
			REG_PAT_LO: cfg_pat_lo = value;
			default:    cfg_pat_hi = value;
		endcase
	endtask

	// All four registers; unused upper bits of mode and length carry noise
	task automatic setup_matcher(input mode_t mode, input logic [4:0] plen,
			input logic [63:0] lo, input logic [63:0] hi);
		logic [63:0] word;
		word = {$urandom, $urandom};
		word[1:0] = mode;
		write_reg(REG_MODE, word);
		word = {$urandom, $urandom};
		word[4:0] = plen;
		write_reg(REG_LEN, word);
		write_reg(REG_PAT_LO, lo);
		write_reg(REG_PAT_HI, hi);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One input beat; payload holds until taken
	task automatic send_char(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Sender pauses until every expected match has come and the block is quiet
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (match_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Bytes that sit near the pattern alphabet: a few letters in both
	// cases, the neighbors of the fold range, and now and then anything
	function automatic logic [7:0] near_byte();
		logic [7:0] b;
		case ($urandom_range(7))
			0, 1, 2, 3: b = CH_UPPER_A + 8'($urandom_range(1));
			4:          b = 8'h5A;
			5: begin
				case ($urandom_range(3))
					0:       b = 8'h40;
					1:       b = 8'h5B;
					2:       b = 8'h60;
					default: b = 8'h7B;
				endcase
			end
			default:    b = 8'($urandom_range(1, 255));
		endcase
		if (b inside {[8'h41:8'h5A]} && $urandom_range(1)) begin
			b = b ^ 8'h20;
		end
		return b;
	endfunction

	// Random string: mostly the pattern with noise around it, case flips,
	// a corrupted byte or a cut; otherwise plain noise. Brief strings keep
	// terminators coming during a hold-off.
	task automatic send_random_string(input bit brief);
		logic [7:0] body [$];
		logic [7:0] p;
		int n;
		int kind;
		int cut;
		int lead;
		n = (cfg_len > PATTERN_MAX) ? PATTERN_MAX : int'(cfg_len);
		kind = brief ? 6 : $urandom_range(9);
		if (kind <= 5) begin
			if ($urandom_range(1)) begin
				repeat ($urandom_range(1, 3)) body.push_back(near_byte());
			end
			lead = body.size();
			cut = (kind == 5 && n > 0) ? $urandom_range(n - 1) : n;
			for (int i = 0; i < cut; i++) begin
				p = pattern_char(i);
				if (p == CH_NUL) begin
					p = near_byte();
				end else if (upcase(p) inside {[8'h41:8'h5A]} && $urandom_range(1)) begin
					p = p ^ 8'h20;
				end
				body.push_back(p);
			end
			if (kind == 4 && cut > 0) begin
				body[lead + $urandom_range(cut - 1)] = near_byte();
			end
			if ($urandom_range(1)) begin
				repeat ($urandom_range(1, 3)) body.push_back(near_byte());
			end
		end else if (kind <= 8) begin
			repeat ($urandom_range(brief ? 3 : 20)) body.push_back(near_byte());
		end else begin
			repeat ($urandom_range(24)) body.push_back(8'($urandom_range(1, 255)));
		end
		foreach (body[i]) begin
			send_char(body[i]);
		end
		send_char(CH_NUL);
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin : stimulus
		mode_t       mode;
		logic [4:0]  plen;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [7:0]  pb;
		int          phase;
		int          pick;
		bit          brief;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: one register setting each, quiet block before every setup
		foreach (PROBES[r]) begin
			drain_results();
			if (PROBES[r].set_cfg) begin
				setup_matcher(PROBES[r].mode, PROBES[r].plen, PROBES[r].pat_lo,
					PROBES[r].pat_hi);
			end
			next_want = PROBES[r].want;
			for (int k = 0; k < PROBES[r].n; k++) begin
				send_char(PROBES[r].text[8*k +: 8]);
			end
			send_char(CH_NUL);
		end
		drain_results();
		next_want = WANT_MODEL;
		items_sent = 0;

		// Random phases: new setting, then a burst of strings
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			// idling regime: sender light / receiver heavy, then swapped, then none
			if (items_sent < RANDOM_ITEMS / 3) begin
				tx_idle_pct = 32;
				rx_idle_pct = 63;
			end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 63;
				rx_idle_pct = 32;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			drain_results();

			// extreme settings first, random after
			case (phase)
				0: begin
					mode = MODE_CONTAINS;
					plen = 5'd31;
					lo = '1;
					hi = '1;
				end
				1: begin
					mode = MODE_EXACT;
					plen = 5'd0;
					lo = '0;
					hi = '0;
				end
				default: begin
					mode = mode_t'($urandom_range(3));
					pick = $urandom_range(19);
					if (phase == 2) begin
						plen = 5'd16;
					end else if (pick < 2) begin
						plen = 5'd0;
					end else if (pick < 13) begin
						plen = 5'($urandom_range(1, 5));
					end else if (pick < 17) begin
						plen = 5'($urandom_range(6, 16));
					end else begin
						plen = 5'($urandom_range(17, 31));
					end
					for (int i = 0; i < 16; i++) begin
						// a zero pattern byte now and then
						pb = ($urandom_range(39) == 0) ? CH_NUL : near_byte();
						if (i < 8) begin
							lo[8*i +: 8] = pb;
						end else begin
							hi[8*(i-8) +: 8] = pb;
						end
					end
				end
			endcase
			setup_matcher(mode, plen, lo, hi);

			// every fifth phase: receiver holds off while short strings keep coming
			brief = (phase % 5 == 2);
			if (brief) begin
				holdoff_requests++;
			end
			repeat ($urandom_range(8, 16)) send_random_string(brief);
			phase++;
		end

		drain_results();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
